// ===== design/vka_pkg.sv =====
// Package for the voxel key id assigner: payload structs, codes, constants.
// No dependencies.
package vka_pkg;

  localparam int unsigned CapacityDefault = 4096;
  localparam int unsigned SizeW = 25;
  localparam int unsigned KeyW = 24;
  localparam int unsigned CoordW = 32;
  localparam int unsigned IdW = 12;
  localparam logic [SizeW-1:0] SizeReset = 25'd65536;

  localparam logic [1:0] OpAssign = 2'd0;
  localparam logic [1:0] OpLookup = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;
  localparam logic [1:0] OpReserved = 2'd3;

  localparam logic [2:0] StFound = 3'd0;
  localparam logic [2:0] StInserted = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StFull = 3'd3;
  localparam logic [2:0] StCleared = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [23:0] query_x;
    logic signed [23:0] query_y;
    logic signed [23:0] query_z;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [11:0] voxel_id;
    logic signed [23:0] cell_x;
    logic signed [23:0] cell_y;
    logic signed [23:0] cell_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture command and size
    logic div_start;  // start three dividers
    logic mul_step;   // compute centers, one axis per step
    logic scan_start; // begin table scan
    logic scan_step;  // advance scan address
    logic insert;     // write key at entry_count
    logic clear;      // empty table
    logic finish;     // present result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic scan_last;  // no more entries to compare
    logic hit;        // registered compare matched
    logic rd_pending; // read data present, compare not yet in hit
    logic is_assign;
    logic is_lookup;
    logic is_clear;
  } sts_t;

endpackage

// ===== design/vka_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module vka_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== design/vka_div.sv =====
// Restoring divider: floor(p / s) for signed p, unsigned s, saturated to a key.
// Depends on vka_pkg.
module vka_div import vka_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CoordW-1:0] p_i,
  input  logic [SizeW-1:0]         s_i,
  output logic                     done_o,
  output logic signed [KeyW-1:0]   key_o
);
  localparam int unsigned CntW = $clog2(CoordW + 1);
  logic [CoordW-1:0] num_q, num_d, quo_q, quo_d;
  logic [SizeW:0]    rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              neg_q, neg_d, busy_q, busy_d;
  logic [SizeW:0]    trial;
  logic [SizeW:0]    shifted;
  logic [CoordW:0]   mag;
  logic signed [CoordW+1:0] q_s;

  // for negative p use magnitude (-p + s - 1) = (-p - 1) + s, handled as ~p then +1 carry trick:
  // floor(p/s) = -(((-p-1) / s) + 1) for p<0
  always_comb begin
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q;
    shifted = {rem_q[SizeW-1:0], num_q[CoordW-1]};
    trial = shifted - {1'b0, s_i};
    if (start_i) begin
      neg_d = p_i[CoordW-1];
      num_d = p_i[CoordW-1] ? ~p_i : p_i;
      quo_d = '0; rem_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[CoordW-2:0], 1'b0};
      if (!trial[SizeW]) begin
        rem_d = trial; quo_d = {quo_q[CoordW-2:0], 1'b1};
      end else begin
        rem_d = shifted; quo_d = {quo_q[CoordW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(CoordW - 1)) busy_d = 1'b0;
    end
  end

  assign mag = {1'b0, quo_q};
  assign q_s = neg_q ? -$signed({1'b0, mag}) - 1 : $signed({1'b0, mag});
  always_comb begin
    if (q_s > $signed((CoordW+2)'(2**(KeyW-1) - 1))) key_o = {1'b0, {(KeyW-1){1'b1}}};
    else if (q_s < -$signed((CoordW+2)'(2**(KeyW-1)))) key_o = {1'b1, {(KeyW-1){1'b0}}};
    else key_o = q_s[KeyW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_o <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
      done_o <= busy_q && !busy_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d; neg_q <= neg_d;
  end
endmodule

// ===== design/vka_datapath.sv =====
// Datapath: dividers, center multiply, key table and scan.
// Depends on vka_pkg, vka_div, vka_ram.
module vka_datapath import vka_pkg::*; #(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctl_t             ctl_i,
  output sts_t             sts_o,
  input  cmd_t             cmd_i,
  input  logic [SizeW-1:0] size_i,
  output rsp_t             rsp_o
);
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);

  cmd_t             cmd_q;
  logic [SizeW-1:0] size_q;
  logic [CntW-1:0]  count_q, scan_q;
  logic             rd_q, hit_q, full_q;
  logic [AddrW-1:0] id_q;
  logic [1:0]       axis_q;
  logic signed [KeyW-1:0] key_q [3];
  logic signed [KeyW-1:0] dkey [3];
  logic [2:0]       ddone;
  logic             div_all;
  logic signed [CoordW-1:0] cen_q [3];
  logic [3*KeyW-1:0] rdata;
  logic [AddrW-1:0] addr;
  logic             we;
  logic             match;
  logic signed [KeyW+SizeW+1:0] prod;
  logic signed [KeyW+SizeW+1:0] cval;
  logic [SizeW-1:0] size_eff;
  logic [AddrW-1:0] last_idx;

  assign size_eff = (size_q == '0) ? SizeW'(1) : size_q;

  for (genvar a = 0; a < 3; a++) begin : g_div
    vka_div u_div (
      .clk_i, .rst_ni, .start_i(ctl_i.div_start),
      .p_i(a == 0 ? cmd_q.point_x : (a == 1 ? cmd_q.point_y : cmd_q.point_z)),
      .s_i(size_eff), .done_o(ddone[a]), .key_o(dkey[a])
    );
  end

  // dividers run in lockstep
  assign div_all = &ddone;

  // one key*size multiply per step, saturating
  assign prod = key_q[axis_q] * $signed({1'b0, size_eff});
  assign cval = prod + $signed((KeyW+SizeW+2)'(size_eff >> 1));

  // insert is dropped when the table is full
  assign we = ctl_i.insert && !full_q;
  assign addr = we ? count_q[AddrW-1:0] : scan_q[AddrW-1:0];
  vka_ram #(.Width(3*KeyW), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr),
    .wdata_i({key_q[0], key_q[1], key_q[2]}), .rdata_o(rdata)
  );

  assign last_idx = AddrW'(scan_q - 1'b1);
  assign match = rd_q && (rdata == {key_q[0], key_q[1], key_q[2]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; rd_q <= 1'b0; hit_q <= 1'b0;
    end else begin
      rd_q <= ctl_i.scan_step;
      if (ctl_i.scan_start) hit_q <= 1'b0;
      else if (match) hit_q <= 1'b1;
      if (ctl_i.clear) count_q <= '0;
      else if (we) count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i; size_q <= size_i; axis_q <= '0;
      key_q[0] <= cmd_i.query_x; key_q[1] <= cmd_i.query_y; key_q[2] <= cmd_i.query_z;
    end
    if (ctl_i.div_start) axis_q <= '0;
    if (div_all) begin
      for (int a = 0; a < 3; a++) key_q[a] <= dkey[a];
    end
    if (ctl_i.mul_step) begin
      if (cval > $signed((KeyW+SizeW+2)'(32'h7fffffff))) cen_q[axis_q] <= 32'h7fffffff;
      else if (cval < -$signed((KeyW+SizeW+2)'(33'h80000000))) cen_q[axis_q] <= 32'h80000000;
      else cen_q[axis_q] <= cval[CoordW-1:0];
      axis_q <= axis_q + 1'b1;
    end
    if (ctl_i.scan_start) scan_q <= '0;
    else if (ctl_i.scan_step) scan_q <= scan_q + 1'b1;
    if (match) id_q <= last_idx;
  end

  assign sts_o.div_done = div_all;
  assign sts_o.scan_last = (scan_q >= count_q);
  assign sts_o.hit = hit_q;
  assign sts_o.rd_pending = rd_q;
  assign sts_o.is_assign = (cmd_q.opcode == OpAssign);
  assign sts_o.is_lookup = (cmd_q.opcode == OpLookup);
  assign sts_o.is_clear = (cmd_q.opcode == OpClear);

  // result assembly
  always_comb begin
    rsp_o = '0;
    if (sts_o.is_clear) begin
      rsp_o.status = StCleared;
    end else if (sts_o.is_assign || sts_o.is_lookup) begin
      rsp_o.cell_x = key_q[0]; rsp_o.cell_y = key_q[1]; rsp_o.cell_z = key_q[2];
      rsp_o.center_x = cen_q[0]; rsp_o.center_y = cen_q[1]; rsp_o.center_z = cen_q[2];
      if (hit_q) begin
        rsp_o.status = StFound; rsp_o.voxel_id = IdW'(id_q);
      end else if (sts_o.is_lookup) begin
        rsp_o.status = StNotFound;
      end else if (full_q) begin
        rsp_o.status = StFull;
      end else begin
        rsp_o.status = StInserted; rsp_o.voxel_id = IdW'(count_q - 1'b1);
      end
    end else begin
      rsp_o.status = StNotFound;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.scan_start) full_q <= (count_q == CntW'(Capacity));
  end
endmodule

// ===== design/vka_ctrl.sv =====
// Controller state machine sequencing clear, divide, multiply, scan, insert.
// Depends on vka_pkg.
module vka_ctrl import vka_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output logic done_o,
  output ctl_t ctl_o,
  input  sts_t sts_i
);
  typedef enum logic [7:0] {
    SIdle  = 8'b0000_0001,
    SDecode= 8'b0000_0010,
    SDiv   = 8'b0000_0100,
    SMul   = 8'b0000_1000,
    SScan  = 8'b0001_0000,
    SDrain = 8'b0010_0000,
    SWrite = 8'b0100_0000,
    SDone  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] mcnt_q, mcnt_d;

  always_comb begin
    state_d = state_q; mcnt_d = mcnt_q; ctl_o = '0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin ctl_o.load = 1'b1; state_d = SDecode; end
      end
      SDecode: begin
        mcnt_d = '0;
        if (sts_i.is_clear) begin ctl_o.clear = 1'b1; state_d = SDone; end
        else if (sts_i.is_assign) begin ctl_o.div_start = 1'b1; state_d = SDiv; end
        else if (sts_i.is_lookup) state_d = SMul;
        else state_d = SDone;
      end
      SDiv: if (sts_i.div_done) state_d = SMul;
      SMul: begin
        ctl_o.mul_step = 1'b1; mcnt_d = mcnt_q + 1'b1;
        if (mcnt_q == 2'd2) begin ctl_o.scan_start = 1'b1; state_d = SScan; end
      end
      SScan: begin
        if (sts_i.hit) state_d = SDone;
        else if (sts_i.scan_last) state_d = SDrain;
        else ctl_o.scan_step = 1'b1;
      end
      SDrain: begin
        if (!sts_i.rd_pending && !sts_i.hit) begin
          if (sts_i.is_assign) state_d = SWrite; else state_d = SDone;
        end else if (sts_i.hit) state_d = SDone;
      end
      // insert; the datapath drops it when the table is full
      SWrite: begin
        ctl_o.insert = 1'b1; state_d = SDone;
      end
      SDone: begin
        ctl_o.finish = 1'b1; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; mcnt_q <= '0;
    end else begin
      state_q <= state_d; mcnt_q <= mcnt_d;
    end
  end

  assign busy_o = (state_q != SIdle);
  assign done_o = ctl_o.finish;
endmodule

// ===== design/voxel_key_id_assigner.sv =====
// Top level of the voxel key id assigner.
// Depends on vka_pkg, vka_ctrl, vka_datapath.
//
// One command per start while busy is low; one result appears for one cycle
// with done and must be taken then. Clear and unknown opcodes go straight to
// done; a lookup scans the table entries, and an assign divides first, then
// scans and inserts on a miss. The scan reads one entry per cycle through the
// key RAM port, and the divide is a 32-step restoring divide. A hit ends the
// scan early.
module voxel_key_id_assigner import vka_pkg::*; #(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd_i,
  output logic             done,
  output rsp_t             rsp_o,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i
);
  ctl_t ctl;
  sts_t sts;
  logic [SizeW-1:0] size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= SizeReset;
    else if (cfg_we_i) size_q <= cfg_wdata_i;
  end

  vka_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .done_o(done),
    .ctl_o(ctl), .sts_i(sts)
  );

  vka_datapath #(.Capacity(Capacity)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts), .cmd_i, .size_i(size_q), .rsp_o(rsp_o)
  );
endmodule
